### src/tam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tam_pkg;

	localparam int CH_W          = 16;
	localparam int MAX_TILE      = 64;
	localparam int MAX_HEIGHT    = 4096;
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int CNT_W         = 13;
	localparam int SUM_W         = CH_W + 12;
	localparam int TS_W          = 7;
	localparam int OFF_W         = 6;
	localparam int ROW_W         = 12;
	localparam int HGT_W         = 13;
	localparam int CFG_W         = 13;
	localparam int CFG_IDX_W     = 2;
	localparam int TC_OUT_W      = 10;
	localparam int FIFO_DEPTH    = 4;
	localparam int NUM_CH        = 4;
	localparam int IN_W          = 64;
	localparam int OUT_W         = 104;
	localparam int RST_TILE      = 8;
	localparam int RST_WIDTH     = 640;
	localparam int RST_HEIGHT    = 480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TILE_SIZE    = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} reg_idx_t;

	typedef enum logic {
		B_IDLE,
		B_UPDATE
	} back_state_t;

	typedef struct packed {
		logic [NUM_CH-1:0][CH_W-1:0] smp;
		logic [ROW_W-1:0]            tile_row;
		logic                        first;
		logic                        emit;
		logic                        done;
	} item_t;

	typedef struct packed {
		logic [NUM_CH-1:0][SUM_W-1:0] sum;
		logic [CNT_W-1:0]             cnt;
	} acc_t;

	typedef struct packed {
		acc_t                acc;
		logic [TC_OUT_W-1:0] tile_col;
		logic [ROW_W-1:0]    tile_row;
		logic                done;
	} div_req_t;

endpackage
`default_nettype wire

### src/tam_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tam_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### src/tam_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tam_front #(
	parameter int MAX_WIDTH = tam_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [tam_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tam_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [tam_pkg::IN_W-1:0]         s_tdata,
	input  wire logic                             pop,
	output logic                                  head_valid,
	output tam_pkg::item_t                        head_item,
	output logic      [$clog2(MAX_WIDTH)-1:0]     head_tc
);

	localparam int AW      = $clog2(MAX_WIDTH);
	localparam int WID_W   = $clog2(MAX_WIDTH + 1);
	localparam int PTR_W   = $clog2(tam_pkg::FIFO_DEPTH);
	localparam int FCNT_W  = $clog2(tam_pkg::FIFO_DEPTH + 1);
	localparam int RST_WID = (tam_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : tam_pkg::RST_WIDTH;

	logic [tam_pkg::TS_W-1:0]  ts_q;
	logic [WID_W-1:0]          width_q;
	logic [tam_pkg::HGT_W-1:0] height_q;
	logic [AW-1:0]             col_q;
	logic [tam_pkg::ROW_W-1:0] row_q;
	logic [tam_pkg::OFF_W-1:0] ox_q;
	logic [tam_pkg::OFF_W-1:0] oy_q;
	logic [AW-1:0]             tc_q;
	logic [tam_pkg::ROW_W-1:0] tr_q;

	logic                      cfg_hit;
	logic [tam_pkg::TS_W-1:0]  ts_new;
	logic [WID_W-1:0]          width_new;
	logic [tam_pkg::HGT_W-1:0] height_new;
	logic                      accept;
	logic                      last_col;
	logic                      last_row;
	logic                      wrap_x;
	logic                      wrap_y;
	tam_pkg::item_t            item;

	tam_pkg::item_t            item_mem [tam_pkg::FIFO_DEPTH];
	logic [AW-1:0]             tc_mem   [tam_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]          wr_ptr_q;
	logic [PTR_W-1:0]          rd_ptr_q;
	logic [FCNT_W-1:0]         fill_q;

	always_comb begin
		cfg_hit = 1'b0;
		unique case (tam_pkg::reg_idx_t'(cfg_index))
			tam_pkg::REG_TILE_SIZE, tam_pkg::REG_IMAGE_WIDTH,
			tam_pkg::REG_IMAGE_HEIGHT: cfg_hit = cfg_we;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_comb begin
		if (cfg_data == '0) begin
			ts_new     = tam_pkg::TS_W'(1);
			width_new  = WID_W'(1);
			height_new = tam_pkg::HGT_W'(1);
		end else begin
			ts_new = (32'(cfg_data) > tam_pkg::MAX_TILE) ?
				tam_pkg::TS_W'(tam_pkg::MAX_TILE) : tam_pkg::TS_W'(cfg_data);
			width_new = (32'(cfg_data) > MAX_WIDTH) ?
				WID_W'(MAX_WIDTH) : WID_W'(cfg_data);
			height_new = (32'(cfg_data) > tam_pkg::MAX_HEIGHT) ?
				tam_pkg::HGT_W'(tam_pkg::MAX_HEIGHT) : tam_pkg::HGT_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q     <= tam_pkg::TS_W'(tam_pkg::RST_TILE);
			width_q  <= WID_W'(RST_WID);
			height_q <= tam_pkg::HGT_W'(tam_pkg::RST_HEIGHT);
		end else if (cfg_we) begin
			unique case (tam_pkg::reg_idx_t'(cfg_index))
				tam_pkg::REG_TILE_SIZE:    ts_q     <= ts_new;
				tam_pkg::REG_IMAGE_WIDTH:  width_q  <= width_new;
				tam_pkg::REG_IMAGE_HEIGHT: height_q <= height_new;
				default: ;
			endcase
		end
	end

	assign s_tready = (fill_q != FCNT_W'(tam_pkg::FIFO_DEPTH));
	assign accept   = s_tvalid && s_tready;

	assign last_col = (32'(col_q) + 1) >= 32'(width_q);
	assign last_row = (32'(row_q) + 1) >= 32'(height_q);
	assign wrap_x   = (32'(ox_q) + 1) >= 32'(ts_q);
	assign wrap_y   = (32'(oy_q) + 1) >= 32'(ts_q);

	always_comb begin
		item.smp      = s_tdata;
		item.tile_row = tr_q;
		item.first    = (ox_q == '0) && (oy_q == '0);
		item.emit     = (last_col || wrap_x) && (last_row || wrap_y);
		item.done     = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ox_q  <= '0;
			oy_q  <= '0;
			tc_q  <= '0;
			tr_q  <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
			ox_q  <= '0;
			oy_q  <= '0;
			tc_q  <= '0;
			tr_q  <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				ox_q  <= '0;
				tc_q  <= '0;
				if (last_row) begin
					row_q <= '0;
					oy_q  <= '0;
					tr_q  <= '0;
				end else begin
					row_q <= row_q + 1'b1;
					if (wrap_y) begin
						oy_q <= '0;
						tr_q <= tr_q + 1'b1;
					end else begin
						oy_q <= oy_q + 1'b1;
					end
				end
			end else begin
				col_q <= col_q + 1'b1;
				if (wrap_x) begin
					ox_q <= '0;
					tc_q <= tc_q + 1'b1;
				end else begin
					ox_q <= ox_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_mem[wr_ptr_q] <= item;
			tc_mem[wr_ptr_q]   <= tc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fill_q <= fill_q + FCNT_W'(accept) - FCNT_W'(pop);
		end
	end

	assign head_valid = (fill_q != '0);
	assign head_item  = item_mem[rd_ptr_q];
	assign head_tc    = tc_mem[rd_ptr_q];

endmodule
`default_nettype wire

### src/tam_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tam_back #(
	parameter int MAX_WIDTH = tam_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         head_valid,
	input  wire tam_pkg::item_t               head_item,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] head_tc,
	output logic                              pop,
	input  wire logic                         div_ready,
	output logic                              div_start,
	output tam_pkg::div_req_t                 div_req
);

	localparam int AW = $clog2(MAX_WIDTH);

	tam_pkg::back_state_t state_q;
	tam_pkg::back_state_t state_nxt;
	tam_pkg::item_t       item_s1;
	logic [AW-1:0]        tc_s1;
	tam_pkg::acc_t        old_acc;
	tam_pkg::acc_t        new_acc;
	logic                 advance;

	tam_ram #(
		.W     ($bits(tam_pkg::acc_t)),
		.DEPTH (MAX_WIDTH)
	) u_store (
		.clk   (clk),
		.we    (advance),
		.waddr (tc_s1),
		.wdata (new_acc),
		.re    (pop),
		.raddr (head_tc),
		.rdata (old_acc)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tam_pkg::B_IDLE:   if (head_valid) state_nxt = tam_pkg::B_UPDATE;
			tam_pkg::B_UPDATE: if (advance) state_nxt = tam_pkg::B_IDLE;
			default:           state_nxt = tam_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop     = 1'b0;
		advance = 1'b0;
		unique case (state_q)
			tam_pkg::B_IDLE:   pop = head_valid;
			tam_pkg::B_UPDATE: advance = !item_s1.emit || div_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tam_pkg::B_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head_item;
			tc_s1   <= head_tc;
		end
	end

	always_comb begin
		for (int c = 0; c < tam_pkg::NUM_CH; c++) begin
			new_acc.sum[c] = (item_s1.first ? '0 : old_acc.sum[c]) +
				tam_pkg::SUM_W'(item_s1.smp[c]);
		end
		new_acc.cnt = item_s1.first ? tam_pkg::CNT_W'(1) : old_acc.cnt + 1'b1;
	end

	assign div_start        = advance && item_s1.emit;
	assign div_req.acc      = new_acc;
	assign div_req.tile_col = tam_pkg::TC_OUT_W'(tc_s1);
	assign div_req.tile_row = item_s1.tile_row;
	assign div_req.done     = item_s1.done;

	a_start_ready: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> div_ready)
		else $error("divider started while busy");

	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tam_pkg::B_UPDATE && !advance) |=>
		(state_q == tam_pkg::B_UPDATE && $stable(tc_s1)))
		else $error("stalled update lost its item");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !advance)
		else $error("read issued during write-back");

endmodule
`default_nettype wire

### src/tam_div.sv
`timescale 1ns / 1ps
`default_nettype none
module tam_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire tam_pkg::div_req_t         req,
	output logic                           ready,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [tam_pkg::OUT_W-1:0]      m_tdata,
	output logic                           m_tlast
);

	localparam int STEP_W = $clog2(tam_pkg::CH_W);
	localparam int HI_W   = tam_pkg::SUM_W - tam_pkg::CH_W;

	logic                        running_q;
	logic                        out_valid_q;
	logic [STEP_W-1:0]           step_q;
	logic [tam_pkg::CNT_W-1:0]   rem_q [tam_pkg::NUM_CH];
	logic [tam_pkg::CH_W-1:0]    quo_q [tam_pkg::NUM_CH];
	logic [tam_pkg::CNT_W-1:0]   rem_nxt [tam_pkg::NUM_CH];
	logic [tam_pkg::CH_W-1:0]    quo_nxt [tam_pkg::NUM_CH];
	logic [tam_pkg::CNT_W-1:0]   dvs_q;
	logic [tam_pkg::CNT_W-1:0]   cnt_q;
	logic [tam_pkg::TC_OUT_W-1:0] col_q;
	logic [tam_pkg::ROW_W-1:0]   row_q;
	logic                        done_q;
	logic                        last_step;

	always_comb begin
		logic [tam_pkg::CNT_W:0] trial;
		logic                    ge;
		for (int c = 0; c < tam_pkg::NUM_CH; c++) begin
			trial      = {rem_q[c], quo_q[c][tam_pkg::CH_W-1]};
			ge         = trial >= {1'b0, dvs_q};
			rem_nxt[c] = ge ? tam_pkg::CNT_W'(trial - {1'b0, dvs_q}) :
				trial[tam_pkg::CNT_W-1:0];
			quo_nxt[c] = {quo_q[c][tam_pkg::CH_W-2:0], ge};
		end
	end

	assign last_step = (step_q == STEP_W'(tam_pkg::CH_W - 1));
	assign ready     = !running_q && !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (start) begin
				running_q <= 1'b1;
				step_q    <= '0;
			end else if (running_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					running_q   <= 1'b0;
					out_valid_q <= 1'b1;
				end
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int c = 0; c < tam_pkg::NUM_CH; c++) begin
				rem_q[c] <= tam_pkg::CNT_W'(req.acc.sum[c][tam_pkg::SUM_W-1 -: HI_W]);
				quo_q[c] <= req.acc.sum[c][tam_pkg::CH_W-1:0];
			end
			dvs_q  <= (req.acc.cnt == '0) ? tam_pkg::CNT_W'(1) : req.acc.cnt;
			cnt_q  <= (req.acc.cnt == '0) ? tam_pkg::CNT_W'(1) : req.acc.cnt;
			col_q  <= req.tile_col;
			row_q  <= req.tile_row;
			done_q <= req.done;
		end else if (running_q) begin
			for (int c = 0; c < tam_pkg::NUM_CH; c++) begin
				rem_q[c] <= rem_nxt[c];
				quo_q[c] <= quo_nxt[c];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = done_q;
	assign m_tdata  = {5'b0, cnt_q, quo_q[3], quo_q[2], quo_q[1], quo_q[0], row_q, col_q};

	a_run_excl: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> !out_valid_q)
		else $error("result shown while dividing");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(running_q && last_step && !start) |=> (out_valid_q && !running_q))
		else $error("division did not finish");

endmodule
`default_nettype wire

### src/tile_average_mosaic.sv
// A tile-closing pixel passes the input FIFO, the column-store update and then the divider.
// Throughput is set by the column store's read-modify-write, which ends before the next read.
// A tile result occupies the 16-step divider until its output transfer.
// Reset restores tile size 8 and a 640 x 480 image and restarts the frame at the top left.
// A configuration write to a known register also restarts the frame.
`timescale 1ns / 1ps
`default_nettype none
module tile_average_mosaic #(
	parameter int MAX_WIDTH = tam_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [tam_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tam_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// hue_in, sat_in, light_in, alpha_in
	input  wire logic [tam_pkg::IN_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// tile_col, tile_row, mean_hue, mean_sat, mean_light, mean_alpha, tile_pixels
	output logic [tam_pkg::OUT_W-1:0]          m_tdata,
	output logic                               m_tlast
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic              head_valid;
	tam_pkg::item_t    head_item;
	logic [AW-1:0]     head_tc;
	logic              pop;
	logic              div_ready;
	logic              div_start;
	tam_pkg::div_req_t div_req;

	tam_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.head_tc    (head_tc)
	);

	tam_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.head_tc    (head_tc),
		.pop        (pop),
		.div_ready  (div_ready),
		.div_start  (div_start),
		.div_req    (div_req)
	);

	tam_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.req      (div_req),
		.ready    (div_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

### tb/sv/tile_average_mosaic_checker.sv
`timescale 1ns / 1ps
module tile_average_mosaic_checker
	import tam_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [IN_W-1:0]      s_tdata,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [OUT_W-1:0]     m_tdata,
	input  wire logic                 m_tlast,
	output int                        mismatches,
	output int                        pending,
	output int                        tiles_seen
);

	localparam int STORE_DEPTH = DEF_MAX_WIDTH;

	typedef struct {
		logic [TC_OUT_W-1:0]    col;
		logic [ROW_W-1:0]       row;
		logic [NUM_CH-1:0][15:0] mean;
		logic [CNT_W-1:0]       pixels;
		logic                   done;
	} tile_mean_t;

	tile_mean_t       tile_means[$];
	logic [SUM_W-1:0] chan_sum[NUM_CH][STORE_DEPTH];
	logic [CNT_W-1:0] pix_cnt[STORE_DEPTH];
	int unsigned      tsize, iwidth, iheight;
	int unsigned      col_pos, row_pos, off_x, off_y;

	function automatic int unsigned clamp_setting(int unsigned v, int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic restart_frame();
		for (int i = 0; i < STORE_DEPTH; i++) begin
			pix_cnt[i] = '0;
			for (int c = 0; c < NUM_CH; c++)
				chan_sum[c][i] = '0;
		end
		col_pos = 0;
		row_pos = 0;
		off_x = 0;
		off_y = 0;
	endtask

	task automatic accumulate_pixel(input logic [IN_W-1:0] px);
		int unsigned     tc, tr;
		bit              last_col, last_row, end_x, end_y;
		longint unsigned cnt;
		tile_mean_t      r;
		tc = (col_pos / tsize) % STORE_DEPTH;
		tr = row_pos / tsize;
		last_col = (col_pos + 1 >= iwidth);
		last_row = (row_pos + 1 >= iheight);
		end_x = last_col || (off_x + 1 >= tsize);
		end_y = last_row || (off_y + 1 >= tsize);
		for (int c = 0; c < NUM_CH; c++) begin
			if (off_x == 0 && off_y == 0)
				chan_sum[c][tc] = SUM_W'(px[CH_W*c +: CH_W]);
			else
				chan_sum[c][tc] = chan_sum[c][tc] + SUM_W'(px[CH_W*c +: CH_W]);
		end
		if (off_x == 0 && off_y == 0)
			pix_cnt[tc] = 1;
		else
			pix_cnt[tc] = pix_cnt[tc] + 1'b1;
		if (end_x && end_y) begin
			cnt = (pix_cnt[tc] == 0) ? 1 : pix_cnt[tc];
			r.col = TC_OUT_W'(tc);
			r.row = ROW_W'(tr);
			for (int c = 0; c < NUM_CH; c++)
				r.mean[c] = 16'(longint'(chan_sum[c][tc]) / cnt);
			r.pixels = CNT_W'(cnt);
			r.done = last_col && last_row;
			tile_means.push_back(r);
		end
		if (last_col) begin
			col_pos = 0;
			off_x = 0;
			if (last_row) begin
				row_pos = 0;
				off_y = 0;
			end else begin
				row_pos++;
				off_y = (off_y + 1 >= tsize) ? 0 : off_y + 1;
			end
		end else begin
			col_pos++;
			off_x = (off_x + 1 >= tsize) ? 0 : off_x + 1;
		end
	endtask

	task automatic check_tile(input logic [OUT_W-1:0] d, input logic last);
		tile_mean_t e, g;
		g.col = d[9:0];
		g.row = d[21:10];
		for (int c = 0; c < NUM_CH; c++)
			g.mean[c] = d[22 + 16*c +: 16];
		g.pixels = d[98:86];
		g.done = last;
		tiles_seen++;
		if (tile_means.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Unexpected tile result col %0d row %0d", g.col, g.row);
			return;
		end
		e = tile_means.pop_front();
		if (e.col !== g.col || e.row !== g.row || e.mean !== g.mean ||
				e.pixels !== g.pixels || e.done !== g.done || d[OUT_W-1:99] !== '0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Tile mismatch: expected col %0d row %0d means %h pixels %0d last %0d, got col %0d row %0d means %h pixels %0d last %0d",
					e.col, e.row, e.mean, e.pixels, e.done,
					g.col, g.row, g.mean, g.pixels, g.done);
		end
	endtask

	initial begin
		mismatches = 0;
		pending = 0;
		tiles_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize = RST_TILE;
			iwidth = RST_WIDTH;
			iheight = RST_HEIGHT;
			restart_frame();
			tile_means.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TILE_SIZE: begin
						tsize = clamp_setting(cfg_data, MAX_TILE);
						restart_frame();
					end
					REG_IMAGE_WIDTH: begin
						iwidth = clamp_setting(cfg_data, STORE_DEPTH);
						restart_frame();
					end
					REG_IMAGE_HEIGHT: begin
						iheight = clamp_setting(cfg_data, MAX_HEIGHT);
						restart_frame();
					end
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				accumulate_pixel(s_tdata);
			if (m_tvalid && m_tready)
				check_tile(m_tdata, m_tlast);
		end
		pending = tile_means.size();
	end

endmodule

### tb/sv/tile_average_mosaic_tb.sv
`timescale 1ns / 1ps
module tile_average_mosaic_tb;
	import tam_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int STALL_CYCLES = 3000;
	localparam int HOLD_CYCLES = 400;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tlast;
	int                   mismatches, pending, tiles_seen;
	int                   pixels_sent = 0;
	int                   setups = 0;
	int                   idle_cycles = 0;
	bit                   no_gaps = 0;
	bit                   hold_req = 0;

	always #10 clk = ~clk;

	tile_average_mosaic dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	tile_average_mosaic_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.mismatches(mismatches), .pending(pending), .tiles_seen(tiles_seen)
	);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int  stall;
		bit  steady;
		int  left;
		left = 0;
		steady = 0;
		forever begin
			if (left == 0) begin
				steady = ($urandom_range(0, 3) == 0);
				left = $urandom_range(20, 60);
			end
			left--;
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 0;
			end else begin
				stall = steady ? 0 : $urandom_range(0, 16);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [IN_W-1:0] random_pixel();
		return {pick_sample(), pick_sample(), pick_sample(), pick_sample()};
	endfunction

	task automatic send_pixel(input logic [IN_W-1:0] px);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pixels_sent++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic configure(input int tsz, input int w, input int h);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_TILE_SIZE;
		cfg_data <= CFG_W'(tsz);
		@(posedge clk);
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= CFG_W'(w);
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= CFG_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		setups++;
	endtask

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_pixel(random_pixel());
	endtask

	initial begin
		int random_left;
		int w, h, tsz;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry, then samples at the extremes.
		send_pixel('0);
		send_pixel('1);
		for (int c = 0; c < NUM_CH; c++)
			send_pixel(IN_W'(64'hffff) << (16 * c));
		send_pixel({4{16'h8000}});

		// Zero tile size acts as one; small frame wraps around.
		configure(0, 3, 2);
		send_pixel('1);
		send_pixel('0);
		send_pixel({4{16'h0001}});
		send_pixel('1);
		send_pixel('1);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_UNUSED;
		cfg_data <= '1;
		@(posedge clk);
		cfg_we <= 1'b0;
		send_pixel('0);
		send_pixel('1);
		send_pixel('1);
		send_pixel('0);

		// Oversized tile and width saturate; one full row of widest tiles.
		configure(127, 2047, 1);
		no_gaps = 1;
		for (int i = 0; i < 1024; i++)
			send_pixel(($urandom_range(0, 1) == 0) ? '1 : random_pixel());
		no_gaps = 0;

		// Zero width and oversized height.
		configure(1, 0, 8191);
		send_random(12);
		configure(64, 1, 4096);
		send_random(70);

		// Receiver holds off while single-pixel tiles keep coming.
		configure(1, 8, 8);
		no_gaps = 1;
		hold_req = 1;
		send_random(64);
		no_gaps = 0;

		random_left = 1300 - pixels_sent;
		while (random_left > 0) begin
			tsz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 40);
			h = $urandom_range(1, 20);
			configure(tsz, w, h);
			no_gaps = ($urandom_range(0, 3) == 0);
			w = $urandom_range(20, 160);
			send_random(w);
			random_left -= w;
		end
		no_gaps = 0;
		settle();

		$display("Covered %0d pixels over %0d geometry setups, %0d tile averages checked.",
			pixels_sent, setups, tiles_seen);
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
src/tam_pkg.sv
src/tam_ram.sv
src/tam_front.sv
src/tam_back.sv
src/tam_div.sv
src/tile_average_mosaic.sv
tb/sv/tile_average_mosaic_checker.sv
tb/sv/tile_average_mosaic_tb.sv
